@@ design/cds_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and calendar helpers for the date subtract block.
// No dependencies.
package cds_pkg;

    localparam int unsigned MAX_COUNT_DEF = 1023;

    localparam int unsigned KIND_W  = 3;
    localparam int unsigned COUNT_W = 10;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    // year held as century and year-of-century, each 0..99
    localparam int unsigned HALF_W  = 7;

    localparam logic [KIND_W-1:0] K_DAY   = 3'd0;
    localparam logic [KIND_W-1:0] K_WEEK  = 3'd1;
    localparam logic [KIND_W-1:0] K_MONTH = 3'd2;
    localparam logic [KIND_W-1:0] K_YEAR  = 3'd3;
    localparam logic [KIND_W-1:0] K_DEC   = 3'd4;
    localparam logic [KIND_W-1:0] K_CENT  = 3'd5;
    localparam logic [KIND_W-1:0] K_MILL  = 3'd6;

    localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1;
    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

    // floor(y / 100) == (y * 5243) >> 19 for y <= 9999
    localparam logic [12:0] RECIP_100  = 13'd5243;
    localparam int unsigned RECIP_SHIFT = 19;

    localparam logic [2:0] WEEK_LAST = 3'd6;

    function automatic logic leap_year(input logic [HALF_W-1:0] cent,
                                       input logic [HALF_W-1:0] yoc);
        logic r;
        if (yoc == '0)
            r = (cent[1:0] == 2'b00);
        else
            r = (yoc[1:0] == 2'b00);
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] r;
        case (m)
            4'd2:                      r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
            default:                   r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

@@ design/calendar_date_subtract_top.sv @@
`timescale 1ns / 1ps
// Gregorian date subtract block: top level with sequencer and step unit.
// Depends on cds_pkg.
//
// Usage:
//   Input channel: i_valid / o_stall carry kind, count and a start date.
//   A request is taken when i_valid is high and o_stall is low. o_stall
//   stays high from the cycle after a request until its result has been
//   loaded into the output register.
//   Output channel: o_valid / i_stall carry the result date and underflow.
//   The result sits in an output register and holds while i_stall is high.
//   Sequence: setup states S_SPLIT, S_NORM and S_CLAMP split the year
//   into century and year-of-century, then clamp the day; S_RUN then
//   applies the day, month or year steps of the shared step unit, and
//   S_DONE loads the output. A week is seven day steps. Underflow
//   ends the stepping at once. Next request can be taken the cycle after
//   the result is loaded, while that result still waits on the output.
//   If the output register is still full when a result is ready, the
//   sequencer waits until the receiver takes the older one.
//   Reset (synchronous, active low) returns the sequencer to idle and
//   empties the output register.
module calendar_date_subtract_top
    import cds_pkg::*;
#(
    parameter int unsigned MAX_COUNT = MAX_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic [COUNT_W-1:0]   i_count,
    input  logic [DAY_W-1:0]     i_in_day,
    input  logic [MONTH_W-1:0]   i_in_month,
    input  logic [YEAR_W-1:0]    i_in_year,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [DAY_W-1:0]     o_out_day,
    output logic [MONTH_W-1:0]   o_out_month,
    output logic [YEAR_W-1:0]    o_out_year,
    output logic                 o_underflow
);

    localparam int unsigned CNT_MAX = (1 << COUNT_W) - 1;
    localparam int unsigned CAP     = (MAX_COUNT < CNT_MAX) ? MAX_COUNT : CNT_MAX;
    localparam logic [COUNT_W-1:0] CAP_V = CAP[COUNT_W-1:0];

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SPLIT = 3'd1;
    localparam logic [2:0] S_NORM  = 3'd2;
    localparam logic [2:0] S_CLAMP = 3'd3;
    localparam logic [2:0] S_RUN   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [KIND_W-1:0]   r_kind;
    logic [COUNT_W-1:0]  r_cnt, n_cnt;
    logic [2:0]          r_sub, n_sub;
    logic [DAY_W-1:0]    r_day, n_day;
    logic [MONTH_W-1:0]  r_month, n_month;
    logic [YEAR_W-1:0]   r_year;
    logic [HALF_W-1:0]   r_cent, n_cent;
    logic [HALF_W-1:0]   r_yoc, n_yoc;
    logic                r_uf, n_uf;

    logic                r_ovalid;
    logic [DAY_W-1:0]    r_oday;
    logic [MONTH_W-1:0]  r_omonth;
    logic [YEAR_W-1:0]   r_oyear;
    logic                r_ouf;

    logic                accept;
    logic                load_out;
    logic [MONTH_W-1:0]  m_clamp;
    logic [YEAR_W-1:0]   y_clamp;
    logic [COUNT_W-1:0]  cnt_sat;
    logic [26:0]         prod;
    logic [YEAR_W-1:0]   cent_x100;
    logic [YEAR_W-1:0]   yoc_wide;
    logic [YEAR_W-1:0]   year_join;

    // step unit signals
    logic                cur_leap, new_leap;
    logic                yr_le1;
    logic [HALF_W-1:0]   dec_cent, dec_yoc;
    logic [HALF_W-1:0]   sp_cent, sp_yoc;
    logic                sp_under;
    logic [MONTH_W-1:0]  prev_m;
    logic [DAY_W-1:0]    prev_len, cur_len;
    logic                unit_end;

    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign load_out = (r_state == S_DONE) && (!r_ovalid || !i_stall);

    assign m_clamp = (i_in_month == '0) ? 4'd1 : ((i_in_month > 4'd12) ? 4'd12 : i_in_month);
    assign y_clamp = (i_in_year == '0) ? YEAR_MIN :
                     ((i_in_year > YEAR_MAX) ? YEAR_MAX : i_in_year);
    assign cnt_sat = (i_count > CAP_V) ? CAP_V : i_count;

    assign prod      = r_year * RECIP_100;
    assign cent_x100 = {1'b0, r_cent, 6'b0} + {2'b0, r_cent, 5'b0} + {5'b0, r_cent, 2'b0};
    assign yoc_wide  = r_year - cent_x100;
    assign year_join = cent_x100 + {7'b0, r_yoc};

    assign cur_leap = leap_year(r_cent, r_yoc);
    assign yr_le1   = (r_cent == '0) && (r_yoc <= 7'd1);
    assign dec_cent = (r_yoc == '0) ? r_cent - 7'd1 : r_cent;
    assign dec_yoc  = (r_yoc == '0) ? 7'd99 : r_yoc - 7'd1;
    assign prev_m   = r_month - 4'd1;
    assign prev_len = month_len(prev_m, cur_leap);
    assign cur_len  = month_len(r_month, cur_leap);
    assign unit_end = (r_kind != K_WEEK) || (r_sub == WEEK_LAST);

    // year-span step: underflow test and new century / year-of-century
    always_comb begin
        sp_cent  = r_cent;
        sp_yoc   = r_yoc;
        sp_under = 1'b0;
        case (r_kind)
            K_YEAR: begin
                sp_under = yr_le1;
                sp_cent  = dec_cent;
                sp_yoc   = dec_yoc;
            end
            K_DEC: begin
                sp_under = (r_cent == '0) && (r_yoc <= 7'd10);
                if (r_yoc < 7'd10) begin
                    sp_cent = r_cent - 7'd1;
                    sp_yoc  = r_yoc + 7'd90;
                end else begin
                    sp_yoc  = r_yoc - 7'd10;
                end
            end
            K_CENT: begin
                sp_under = (r_cent == '0) || ((r_cent == 7'd1) && (r_yoc == '0));
                sp_cent  = r_cent - 7'd1;
            end
            K_MILL: begin
                sp_under = (r_cent < 7'd10) || ((r_cent == 7'd10) && (r_yoc == '0));
                sp_cent  = r_cent - 7'd10;
            end
            default: ;
        endcase
    end

    assign new_leap = leap_year(sp_cent, sp_yoc);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_sub   = r_sub;
        n_day   = r_day;
        n_month = r_month;
        n_cent  = r_cent;
        n_yoc   = r_yoc;
        n_uf    = r_uf;
        case (r_state)
            S_IDLE: begin
                if (accept)
                    n_state = S_SPLIT;
            end
            S_SPLIT: begin
                n_cent  = prod[RECIP_SHIFT+HALF_W-1:RECIP_SHIFT];
                n_state = S_NORM;
            end
            S_NORM: begin
                n_yoc   = yoc_wide[HALF_W-1:0];
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                if (r_day == '0)
                    n_day = 5'd1;
                else if (r_day > cur_len)
                    n_day = cur_len;
                if (r_cnt == '0 || r_kind > K_MILL)
                    n_state = S_DONE;
                else
                    n_state = S_RUN;
            end
            S_RUN: begin
                case (r_kind)
                    K_DAY, K_WEEK: begin
                        if (r_day > 5'd1) begin
                            n_day = r_day - 5'd1;
                        end else if (r_month == 4'd1) begin
                            if (yr_le1) begin
                                n_uf = 1'b1;
                            end else begin
                                n_cent  = dec_cent;
                                n_yoc   = dec_yoc;
                                n_month = 4'd12;
                                n_day   = 5'd31;
                            end
                        end else begin
                            n_month = prev_m;
                            n_day   = prev_len;
                        end
                    end
                    K_MONTH: begin
                        if (r_month == 4'd1) begin
                            if (yr_le1) begin
                                n_uf = 1'b1;
                            end else begin
                                n_cent  = dec_cent;
                                n_yoc   = dec_yoc;
                                n_month = 4'd12;
                            end
                        end else begin
                            n_month = prev_m;
                            if (r_day > prev_len)
                                n_day = prev_len;
                        end
                    end
                    default: begin
                        if (sp_under) begin
                            n_uf = 1'b1;
                        end else begin
                            n_cent = sp_cent;
                            n_yoc  = sp_yoc;
                            if (r_month == 4'd2) begin
                                if (!new_leap && r_day == 5'd29)
                                    n_day = 5'd28;
                                else if (new_leap && r_day == 5'd28)
                                    n_day = 5'd29;
                            end
                        end
                    end
                endcase
                if (n_uf) begin
                    n_state = S_DONE;
                end else if (unit_end) begin
                    n_sub = '0;
                    n_cnt = r_cnt - 10'd1;
                    if (r_cnt == 10'd1)
                        n_state = S_DONE;
                end else begin
                    n_sub = r_sub + 3'd1;
                end
            end
            S_DONE: begin
                if (load_out)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out)
                r_ovalid <= 1'b1;
            else if (!i_stall)
                r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_kind;
            r_cnt   <= cnt_sat;
            r_sub   <= '0;
            r_day   <= i_in_day;
            r_month <= m_clamp;
            r_year  <= y_clamp;
            r_uf    <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_sub   <= n_sub;
            r_day   <= n_day;
            r_month <= n_month;
            r_uf    <= n_uf;
        end
        r_cent <= n_cent;
        r_yoc  <= n_yoc;
        if (load_out) begin
            r_ouf <= r_uf;
            if (r_uf) begin
                r_oday   <= 5'd1;
                r_omonth <= 4'd1;
                r_oyear  <= YEAR_MIN;
            end else begin
                r_oday   <= r_day;
                r_omonth <= r_month;
                r_oyear  <= year_join;
            end
        end
    end

    assign o_valid     = r_ovalid;
    assign o_out_day   = r_oday;
    assign o_out_month = r_omonth;
    assign o_out_year  = r_oyear;
    assign o_underflow = r_ouf;

endmodule

@@ verif/tb_calendar_date_subtract_top.sv @@
`timescale 1ns / 1ps
// Testbench for calendar_date_subtract_top: directed and random date requests,
// checked against a date predictor in a small scoreboard. Depends on cds_pkg.
module tb_calendar_date_subtract_top
    import cds_pkg::*;
;

    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned TAIL_CYCLES = 40;
    localparam int unsigned IDLE_PCT    = 19;
    localparam int unsigned RAND_ITEMS  = 100;

    // kind code with no unit: block returns the normalized start date
    localparam logic [KIND_W-1:0] K_UNUSED = 3'd7;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               underflow;
    } t_date_result;

    class date_scoreboard;
        t_date_result expected_dates[$];
        int unsigned  n_errors;

        function new();
            n_errors = 0;
        endfunction

        function bit is_leap(int unsigned y);
            return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        endfunction

        function int unsigned days_in(int unsigned y, int unsigned m);
            case (m)
                2: begin
                    return is_leap(y) ? 29 : 28;
                end
                4, 6, 9, 11: begin
                    return 30;
                end
                default: begin
                    return 31;
                end
            endcase
        endfunction

        function bit day_back(inout int unsigned d, inout int unsigned m,
                              inout int unsigned y);
            if (d > 1) begin
                d--;
                return 1'b1;
            end
            if (m == 1) begin
                if (y <= 1)
                    return 1'b0;
                y--;
                m = 12;
                d = 31;
            end else begin
                m--;
                d = days_in(y, m);
            end
            return 1'b1;
        endfunction

        function bit month_back(inout int unsigned d, inout int unsigned m,
                                inout int unsigned y);
            int unsigned len;
            if (m == 1) begin
                if (y <= 1)
                    return 1'b0;
                y--;
                m = 12;
            end else begin
                m--;
            end
            len = days_in(y, m);
            if (d > len)
                d = len;
            return 1'b1;
        endfunction

        // February fix-up applies in the target year only
        function bit years_back(inout int unsigned d, input int unsigned m,
                                inout int unsigned y, input int unsigned span);
            if (y <= span)
                return 1'b0;
            y -= span;
            if (m == 2) begin
                if (!is_leap(y) && d == 29)
                    d = 28;
                else if (is_leap(y) && d == 28)
                    d = 29;
            end
            return 1'b1;
        endfunction

        function t_date_result subtract_date(logic [KIND_W-1:0] kind,
                                             logic [COUNT_W-1:0] count,
                                             logic [DAY_W-1:0] day,
                                             logic [MONTH_W-1:0] month,
                                             logic [YEAR_W-1:0] year);
            int unsigned  cnt, d, m, y, len;
            bit           ok;
            t_date_result r;
            ok  = 1'b1;
            cnt = count;
            if (cnt > MAX_COUNT_DEF)
                cnt = MAX_COUNT_DEF;
            m = month;
            if (m < 1)
                m = 1;
            if (m > 12)
                m = 12;
            y = year;
            if (y < 1)
                y = 1;
            if (y > 9999)
                y = 9999;
            len = days_in(y, m);
            d = day;
            if (d < 1)
                d = 1;
            if (d > len)
                d = len;
            for (int unsigned i = 0; ok && i < cnt; i++) begin
                case (kind)
                    K_DAY: begin
                        ok = day_back(d, m, y);
                    end
                    K_WEEK: begin
                        for (int k = 0; ok && k < 7; k++)
                            ok = day_back(d, m, y);
                    end
                    K_MONTH: begin
                        ok = month_back(d, m, y);
                    end
                    K_YEAR: begin
                        ok = years_back(d, m, y, 1);
                    end
                    K_DEC: begin
                        ok = years_back(d, m, y, 10);
                    end
                    K_CENT: begin
                        ok = years_back(d, m, y, 100);
                    end
                    K_MILL: begin
                        ok = years_back(d, m, y, 1000);
                    end
                    default: begin
                        break;
                    end
                endcase
            end
            if (!ok) begin
                d = 1;
                m = 1;
                y = 1;
            end
            r.day       = DAY_W'(d);
            r.month     = MONTH_W'(m);
            r.year      = YEAR_W'(y);
            r.underflow = !ok;
            return r;
        endfunction

        function void note_request(logic [KIND_W-1:0] kind, logic [COUNT_W-1:0] count,
                                   logic [DAY_W-1:0] day, logic [MONTH_W-1:0] month,
                                   logic [YEAR_W-1:0] year);
            expected_dates.push_back(subtract_date(kind, count, day, month, year));
        endfunction

        function int unsigned pending();
            return expected_dates.size();
        endfunction

        task report(string what);
            n_errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(logic [DAY_W-1:0] day, logic [MONTH_W-1:0] month,
                          logic [YEAR_W-1:0] year, logic underflow);
            t_date_result want;
            if (expected_dates.size() == 0) begin
                report($sformatf("unexpected result %0d/%0d/%0d uf=%0b",
                                 day, month, year, underflow));
                return;
            end
            want = expected_dates.pop_front();
            if (day !== want.day)
                report($sformatf("day got %0d want %0d", day, want.day));
            if (month !== want.month)
                report($sformatf("month got %0d want %0d", month, want.month));
            if (year !== want.year)
                report($sformatf("year got %0d want %0d", year, want.year));
            if (underflow !== want.underflow)
                report($sformatf("underflow got %0b want %0b", underflow, want.underflow));
        endtask
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic               i_stall     = 1'b0;
    logic [KIND_W-1:0]  i_kind      = '0;
    logic [COUNT_W-1:0] i_count     = '0;
    logic [DAY_W-1:0]   i_in_day    = '0;
    logic [MONTH_W-1:0] i_in_month  = '0;
    logic [YEAR_W-1:0]  i_in_year   = '0;
    logic               o_stall;
    logic               o_valid;
    logic [DAY_W-1:0]   o_out_day;
    logic [MONTH_W-1:0] o_out_month;
    logic [YEAR_W-1:0]  o_out_year;
    logic               o_underflow;

    date_scoreboard sb = new();

    bit          quiet      = 1'b0;   // no idling on either side
    bit          hold_start = 1'b0;
    int unsigned hold_left  = 0;
    int unsigned cycle_count;

    calendar_date_subtract_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_count     (i_count),
        .i_in_day    (i_in_day),
        .i_in_month  (i_in_month),
        .i_in_year   (i_in_year),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_day   (o_out_day),
        .o_out_month (o_out_month),
        .o_out_year  (o_out_year),
        .o_underflow (o_underflow)
    );

    always #10 i_clk = ~i_clk;

    // result side: check accepted results, then pick next stall value
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall)
            sb.check_result(o_out_day, o_out_month, o_out_year, o_underflow);
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [COUNT_W-1:0] count,
                                input logic [DAY_W-1:0] day,
                                input logic [MONTH_W-1:0] month,
                                input logic [YEAR_W-1:0] year);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_count    <= count;
        i_in_day   <= day;
        i_in_month <= month;
        i_in_year  <= year;
        do
            @(posedge i_clk);
        while (o_stall !== 1'b0);
        sb.note_request(kind, count, day, month, year);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_random();
        int unsigned r, kind, count, day, month, year, nm, ny;
        int unsigned leap_marks[6] = '{1600, 1700, 1900, 2000, 2100, 2400};
        r = $urandom_range(0, 99);
        kind = (r < 3) ? K_UNUSED : $urandom_range(0, 6);
        r = $urandom_range(0, 99);
        count = (r < 8) ? $urandom_range(0, 1023) : $urandom_range(0, 24);
        r = $urandom_range(0, 99);
        month = (r < 6) ? $urandom_range(0, 15) : $urandom_range(1, 12);
        r = $urandom_range(0, 99);
        if (r < 5)
            year = $urandom_range(0, 16383);
        else if (r < 30)
            year = $urandom_range(1, 40);   // near the underflow edge
        else if (r < 45)
            year = leap_marks[$urandom_range(0, 5)] + $urandom_range(0, 4);
        else
            year = $urandom_range(1, 9999);
        nm = (month < 1) ? 1 : (month > 12) ? 12 : month;
        ny = (year < 1) ? 1 : (year > 9999) ? 9999 : year;
        r = $urandom_range(0, 99);
        if (r < 6)
            day = $urandom_range(0, 31);
        else if (nm == 2 && r < 40)
            day = $urandom_range(28, 29);
        else
            day = $urandom_range(1, sb.days_in(ny, nm));
        send_request(KIND_W'(kind), COUNT_W'(count), DAY_W'(day),
                     MONTH_W'(month), YEAR_W'(year));
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero count, unused kind, normalization of out-of-range fields
        send_request(K_DAY,    10'd0,    5'd31, 4'd12, 14'd9999);
        send_request(K_UNUSED, 10'd5,    5'd15, 4'd6,  14'd2000);
        send_request(K_DAY,    10'd0,    5'd0,  4'd0,  14'd0);
        send_request(K_DAY,    10'd0,    5'd31, 4'd15, 14'd16383);
        send_request(K_DAY,    10'd0,    5'd31, 4'd2,  14'd2000);
        send_request(K_YEAR,   10'd1,    5'd30, 4'd2,  14'd1900);
        // day wraps, leap February, underflow
        send_request(K_DAY,    10'd1,    5'd1,  4'd3,  14'd2000);
        send_request(K_DAY,    10'd1,    5'd1,  4'd3,  14'd1900);
        send_request(K_DAY,    10'd1,    5'd1,  4'd1,  14'd2);
        send_request(K_DAY,    10'd1,    5'd1,  4'd1,  14'd1);
        send_request(K_DAY,    10'd1023, 5'd1,  4'd1,  14'd3);
        send_request(K_WEEK,   10'd1,    5'd5,  4'd1,  14'd1);
        send_request(K_WEEK,   10'd1023, 5'd8,  4'd3,  14'd2024);
        // month clamp and full count
        send_request(K_MONTH,  10'd1,    5'd31, 4'd3,  14'd2023);
        send_request(K_MONTH,  10'd1,    5'd31, 4'd1,  14'd1);
        send_request(K_MONTH,  10'd1023, 5'd15, 4'd7,  14'd5000);
        // year kinds with the February rule
        send_request(K_YEAR,   10'd1,    5'd29, 4'd2,  14'd2024);
        send_request(K_YEAR,   10'd1,    5'd28, 4'd2,  14'd2025);
        send_request(K_YEAR,   10'd1023, 5'd31, 4'd12, 14'd9999);
        send_request(K_DEC,    10'd10,   5'd29, 4'd2,  14'd2000);
        send_request(K_CENT,   10'd1,    5'd28, 4'd2,  14'd2100);
        send_request(K_MILL,   10'd9,    5'd15, 4'd5,  14'd9999);
        send_request(K_MILL,   10'd1,    5'd1,  4'd1,  14'd1000);
        drain();

        for (int idx = 0; idx < RAND_ITEMS; idx++) begin
            if (idx == 30)
                quiet = 1'b1;
            if (idx == 45)
                hold_start = 1'b1;   // receiver backs up, block fills
            if (idx == 60)
                quiet = 1'b0;
            if (idx == 75)
                drain();
            send_random();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
